// ----- hdl/jcpm_pkg.sv -----
// ----------------------------------------------------------------------------
// jcpm_pkg
// Shared types and constants of the joint command priority merge block.
// ----------------------------------------------------------------------------
package jcpm_pkg;

    // field widths of the input item
    localparam int unsigned SRC_W   = 2;
    localparam int unsigned CHAN_W  = 8;
    localparam int unsigned ANGLE_W = 16;

    // field widths of the result item
    localparam int unsigned CMD_CH_W = 6;
    localparam int unsigned MODE_W   = 2;
    localparam int unsigned PEND_W   = 7;

    // stream widths, packed from the lowest bit, padded to whole bytes
    localparam int unsigned S_TDATA_W = 32;
    localparam int unsigned M_TDATA_W = 40;

    // one slot entry as held in the slot memory
    localparam int unsigned SLOT_W = SRC_W + ANGLE_W;

    // request kinds carried in tuser
    localparam logic REQ_SUBMIT = 1'b0;
    localparam logic REQ_FLUSH  = 1'b1;

    // command sources, the code is also the priority
    localparam logic [SRC_W-1:0] SRC_UI      = 2'd0;
    localparam logic [SRC_W-1:0] SRC_GAIT    = 2'd1;
    localparam logic [SRC_W-1:0] SRC_BALANCE = 2'd2;
    localparam logic [SRC_W-1:0] SRC_UNKNOWN = 2'd3;

    // write modes of an emitted command
    localparam logic [MODE_W-1:0] MODE_DIRECT_JOINT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SMOOTH_JOINT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SMOOTH_ABS   = 2'd2;

    // map a known source to its write mode
    function automatic logic [MODE_W-1:0] src_to_mode(input logic [SRC_W-1:0] src);
        logic [MODE_W-1:0] mode;
        unique case (src)
            SRC_BALANCE: mode = MODE_DIRECT_JOINT;
            SRC_GAIT:    mode = MODE_SMOOTH_JOINT;
            SRC_UI:      mode = MODE_SMOOTH_ABS;
            default:     mode = MODE_DIRECT_JOINT;
        endcase
        return mode;
    endfunction

endpackage

// ----- hdl/jcpm_ram.sv -----
// ----------------------------------------------------------------------------
// jcpm_ram
// Generic single write port, single read port memory with registered read.
// ----------------------------------------------------------------------------
module jcpm_ram #(
    parameter int unsigned WIDTH = 18,
    parameter int unsigned DEPTH = 16
) (
    input  logic                                    aclk,
    input  logic                                    wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                        wr_data,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                        rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- hdl/joint_command_priority_merge.sv -----
// Timing: an in-range submit passes through ST_SUB_CMP before its result is registered
// in ST_OUT; an out-of-range submit and a flush that emits nothing go straight to ST_OUT.
// Throughput: one item at a time, the input is not ready until the last result is taken;
// an emitting flush walks the slots in ST_FL_SCAN up to its last command, with an
// ST_FL_EMIT step and one result handshake per command.
// Reset (aresetn low, synchronous): all slots empty, gateway_ready 0, no result held.
// ----------------------------------------------------------------------------
// joint_command_priority_merge
// Per-joint priority arbiter: submits merge into one slot per joint; a gateway-on flush
// without estop walks the slots in channel order and emits the commands of known sources.
// ----------------------------------------------------------------------------
module joint_command_priority_merge
    import jcpm_pkg::*;
#(
    parameter int unsigned JOINT_COUNT = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    // configuration: gateway_ready
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cfg_data,

    // input items
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // source [1:0], channel [9:2], angle [25:10], estop [26], zero [31:27]
    input  logic [S_TDATA_W-1:0] s_tdata,
    // req_type [0]
    input  logic                 s_tuser,

    // result items
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // cmd_channel [5:0], cmd_angle [21:6], write_mode [23:22], accepted [24],
    // out_of_range [25], pending_count [32:26], zero [39:33]
    output logic [M_TDATA_W-1:0] m_tdata,
    // cmd_valid [0]
    output logic                 m_tuser,
    output logic                 m_tlast
);

    localparam int unsigned IDX_W = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;
    localparam logic [CHAN_W-1:0] JOINT_LIMIT = CHAN_W'(JOINT_COUNT);
    localparam logic [IDX_W-1:0]  IDX_LAST    = IDX_W'(JOINT_COUNT - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUB_CMP,
        ST_FL_SCAN,
        ST_FL_EMIT,
        ST_OUT
    } state_t;

    // input field unpacking
    logic [SRC_W-1:0]   in_source;
    logic [CHAN_W-1:0]  in_channel;
    logic [ANGLE_W-1:0] in_angle;
    logic               in_estop;

    assign in_source  = s_tdata[1:0];
    assign in_channel = s_tdata[9:2];
    assign in_angle   = s_tdata[25:10];
    assign in_estop   = s_tdata[26];

    // control state
    state_t                 state_reg, state_next;
    logic                   gateway_reg, gateway_next;
    logic [JOINT_COUNT-1:0] occ_reg, occ_next;
    logic [JOINT_COUNT-1:0] known_reg, known_next;
    logic [PEND_W-1:0]      pend_reg, pend_next;
    logic [PEND_W-1:0]      emit_cnt_reg, emit_cnt_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    logic                   walk_reg, walk_next;
    logic                   m_valid_reg, m_valid_next;

    // captured submit
    logic [SRC_W-1:0]   src_reg, src_next;
    logic [ANGLE_W-1:0] angle_reg, angle_next;

    // result payload
    logic                cmd_valid_reg, cmd_valid_next;
    logic [CMD_CH_W-1:0] cmd_ch_reg, cmd_ch_next;
    logic [ANGLE_W-1:0]  cmd_angle_reg, cmd_angle_next;
    logic [MODE_W-1:0]   mode_reg, mode_next;
    logic                last_reg, last_next;
    logic                acc_reg, acc_next;
    logic                oor_reg, oor_next;
    logic [PEND_W-1:0]   res_pend_reg, res_pend_next;

    // slot memory ports
    logic               ram_wr_en;
    logic [IDX_W-1:0]   ram_wr_addr;
    logic [SLOT_W-1:0]  ram_wr_data;
    logic [IDX_W-1:0]   ram_rd_addr;
    logic [SLOT_W-1:0]  ram_rd_data;
    logic [SRC_W-1:0]   rd_src;
    logic [ANGLE_W-1:0] rd_angle;

    assign rd_src   = ram_rd_data[SLOT_W-1:ANGLE_W];
    assign rd_angle = ram_rd_data[ANGLE_W-1:0];

    // source and angle of each slot
    jcpm_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (JOINT_COUNT)
    ) u_slot_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // handshakes and result packing
    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_valid_reg;
    assign m_tuser   = cmd_valid_reg;
    assign m_tlast   = last_reg;
    assign m_tdata   = {(M_TDATA_W - 33)'(0), res_pend_reg, oor_reg, acc_reg, mode_reg,
                        cmd_angle_reg, cmd_ch_reg};

    // sequencer
    always_comb begin
        logic take;
        logic new_known;

        state_next     = state_reg;
        gateway_next   = gateway_reg;
        occ_next       = occ_reg;
        known_next     = known_reg;
        pend_next      = pend_reg;
        emit_cnt_next  = emit_cnt_reg;
        idx_next       = idx_reg;
        walk_next      = walk_reg;
        m_valid_next   = m_valid_reg;
        src_next       = src_reg;
        angle_next     = angle_reg;
        cmd_valid_next = cmd_valid_reg;
        cmd_ch_next    = cmd_ch_reg;
        cmd_angle_next = cmd_angle_reg;
        mode_next      = mode_reg;
        last_next      = last_reg;
        acc_next       = acc_reg;
        oor_next       = oor_reg;
        res_pend_next  = res_pend_reg;

        ram_wr_en   = 1'b0;
        ram_wr_addr = idx_reg;
        ram_wr_data = {src_reg, angle_reg};
        ram_rd_addr = idx_reg;
        take        = 1'b0;
        new_known   = 1'b0;

        // register write, accepted in any state
        if (cfg_valid) begin
            gateway_next = cfg_data;
        end

        unique case (state_reg)
            ST_IDLE: begin
                ram_rd_addr = in_channel[IDX_W-1:0];
                if (s_tvalid) begin
                    // defaults for a status result
                    cmd_valid_next = 1'b0;
                    cmd_ch_next    = '0;
                    cmd_angle_next = '0;
                    mode_next      = MODE_DIRECT_JOINT;
                    last_next      = 1'b1;
                    acc_next       = 1'b0;
                    oor_next       = 1'b0;
                    res_pend_next  = pend_reg;
                    if (s_tuser == REQ_SUBMIT) begin
                        src_next   = in_source;
                        angle_next = in_angle;
                        idx_next   = in_channel[IDX_W-1:0];
                        if (in_channel >= JOINT_LIMIT) begin
                            oor_next     = 1'b1;
                            m_valid_next = 1'b1;
                            state_next   = ST_OUT;
                        end else begin
                            state_next = ST_SUB_CMP;
                        end
                    end else if (!gateway_reg) begin
                        m_valid_next = 1'b1;
                        state_next   = ST_OUT;
                    end else if (in_estop || emit_cnt_reg == '0) begin
                        occ_next      = '0;
                        known_next    = '0;
                        pend_next     = '0;
                        emit_cnt_next = '0;
                        res_pend_next = '0;
                        m_valid_next  = 1'b1;
                        state_next    = ST_OUT;
                    end else begin
                        // start the slot walk
                        occ_next   = '0;
                        pend_next  = '0;
                        idx_next   = '0;
                        walk_next  = 1'b1;
                        state_next = ST_FL_SCAN;
                    end
                end
            end

            ST_SUB_CMP: begin
                // slot data read at acceptance is valid now
                take      = !occ_reg[idx_reg] || (src_reg >= rd_src);
                new_known = (src_reg != SRC_UNKNOWN);
                if (take) begin
                    ram_wr_en           = 1'b1;
                    occ_next[idx_reg]   = 1'b1;
                    known_next[idx_reg] = new_known;
                    if (!occ_reg[idx_reg]) begin
                        pend_next = pend_reg + PEND_W'(1);
                    end
                    if (new_known && !known_reg[idx_reg]) begin
                        emit_cnt_next = emit_cnt_reg + PEND_W'(1);
                    end else if (!new_known && known_reg[idx_reg]) begin
                        emit_cnt_next = emit_cnt_reg - PEND_W'(1);
                    end
                end
                acc_next      = take;
                res_pend_next = take && !occ_reg[idx_reg] ? pend_reg + PEND_W'(1)
                                                          : pend_reg;
                m_valid_next  = 1'b1;
                state_next    = ST_OUT;
            end

            ST_FL_SCAN: begin
                // read the slot at the walk index, skip slots with nothing to emit
                if (known_reg[idx_reg]) begin
                    state_next = ST_FL_EMIT;
                end else if (idx_reg == IDX_LAST) begin
                    walk_next     = 1'b0;
                    known_next    = '0;
                    emit_cnt_next = '0;
                    state_next    = ST_IDLE;
                end else begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end

            ST_FL_EMIT: begin
                cmd_valid_next      = 1'b1;
                cmd_ch_next         = CMD_CH_W'(idx_reg);
                cmd_angle_next      = rd_angle;
                mode_next           = src_to_mode(rd_src);
                last_next           = (emit_cnt_reg == PEND_W'(1));
                acc_next            = 1'b0;
                oor_next            = 1'b0;
                res_pend_next       = '0;
                emit_cnt_next       = emit_cnt_reg - PEND_W'(1);
                known_next[idx_reg] = 1'b0;
                m_valid_next        = 1'b1;
                state_next          = ST_OUT;
            end

            ST_OUT: begin
                if (m_tready) begin
                    m_valid_next = 1'b0;
                    if (walk_reg && !last_reg) begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = ST_FL_SCAN;
                    end else begin
                        walk_next  = 1'b0;
                        state_next = ST_IDLE;
                    end
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            gateway_reg  <= 1'b0;
            occ_reg      <= '0;
            known_reg    <= '0;
            pend_reg     <= '0;
            emit_cnt_reg <= '0;
            idx_reg      <= '0;
            walk_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            gateway_reg  <= gateway_next;
            occ_reg      <= occ_next;
            known_reg    <= known_next;
            pend_reg     <= pend_next;
            emit_cnt_reg <= emit_cnt_next;
            idx_reg      <= idx_next;
            walk_reg     <= walk_next;
            m_valid_reg  <= m_valid_next;
        end
        src_reg       <= src_next;
        angle_reg     <= angle_next;
        cmd_valid_reg <= cmd_valid_next;
        cmd_ch_reg    <= cmd_ch_next;
        cmd_angle_reg <= cmd_angle_next;
        mode_reg      <= mode_next;
        last_reg      <= last_next;
        acc_reg       <= acc_next;
        oor_reg       <= oor_next;
        res_pend_reg  <= res_pend_next;
    end

endmodule

// ----- sim/tb_joint_command_priority_merge.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_joint_command_priority_merge
// Self-checking bench for the joint command priority merge. A queue-fed driver
// offers submit and flush items, a clocked monitor predicts the result items
// from its own copy of the slots and compares every result field by field.
// ----------------------------------------------------------------------------
module tb_joint_command_priority_merge;
    import jcpm_pkg::*;

    localparam int unsigned JOINTS      = 16;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned SETTLE      = 40;

    // one input item before packing
    typedef struct packed {
        logic               kind;
        logic [SRC_W-1:0]   src;
        logic [CHAN_W-1:0]  chan;
        logic [ANGLE_W-1:0] ang;
        logic               estop;
    } joint_req_t;

    // one result item as the block should emit it
    typedef struct packed {
        logic                cmd_valid;
        logic [CMD_CH_W-1:0] chan;
        logic [ANGLE_W-1:0]  ang;
        logic [MODE_W-1:0]   mode;
        logic                last;
        logic                acc;
        logic                oor;
        logic [PEND_W-1:0]   pend;
    } joint_result_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic                 cfg_data  = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 s_tuser   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;
    logic                 m_tlast;

    // stimulus and expectations
    joint_req_t    req_q[$];
    joint_result_t due_results[$];
    int unsigned   reqs_offered  = 0;
    int unsigned   reqs_taken    = 0;
    int unsigned   fail_count    = 0;
    int unsigned   cycles        = 0;
    int unsigned   send_idle_pct = 0;
    int unsigned   recv_idle_pct = 0;
    int unsigned   hold_left     = 0;
    bit            hold_arm      = 1'b0;
    bit            hold_used     = 1'b0;

    // shadow of the slot memory and the register
    logic               shadow_occ [JOINTS];
    logic [SRC_W-1:0]   shadow_src [JOINTS];
    logic [ANGLE_W-1:0] shadow_ang [JOINTS];
    logic               gateway_on = 1'b0;

    joint_command_priority_merge #(
        .JOINT_COUNT (JOINTS)
    ) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always #2 aclk = ~aclk;

    // occupied slots in the shadow
    function automatic logic [PEND_W-1:0] shadow_pending();
        logic [PEND_W-1:0] n;
        n = '0;
        for (int i = 0; i < JOINTS; i++) n += PEND_W'(shadow_occ[i]);
        return n;
    endfunction

    // status result without a command
    function automatic joint_result_t status_result(logic acc, logic oor,
                                                    logic [PEND_W-1:0] pend);
        joint_result_t r;
        r = '0;
        r.last = 1'b1;
        r.acc  = acc;
        r.oor  = oor;
        r.pend = pend;
        return r;
    endfunction

    // merge one accepted item into the shadow and queue its results
    task automatic merge_item(input joint_req_t q);
        logic          acc;
        logic          oor;
        logic          have_prev;
        joint_result_t prev;
        joint_result_t cur;
        acc       = 1'b0;
        oor       = 1'b0;
        have_prev = 1'b0;
        prev      = '0;
        if (q.kind == REQ_SUBMIT) begin
            if (q.chan >= JOINTS) begin
                oor = 1'b1;
            end else if (!shadow_occ[q.chan] || q.src >= shadow_src[q.chan]) begin
                shadow_occ[q.chan] = 1'b1;
                shadow_src[q.chan] = q.src;
                shadow_ang[q.chan] = q.ang;
                acc = 1'b1;
            end
            due_results.push_back(status_result(acc, oor, shadow_pending()));
        end else if (!gateway_on) begin
            due_results.push_back(status_result(1'b0, 1'b0, shadow_pending()));
        end else begin
            // walk the slots in channel order, unknown sources give nothing
            if (!q.estop) begin
                for (int i = 0; i < JOINTS; i++) begin
                    if (shadow_occ[i] && shadow_src[i] != SRC_UNKNOWN) begin
                        cur           = '0;
                        cur.cmd_valid = 1'b1;
                        cur.chan      = i[CMD_CH_W-1:0];
                        cur.ang       = shadow_ang[i];
                        case (shadow_src[i])
                            SRC_BALANCE: cur.mode = MODE_DIRECT_JOINT;
                            SRC_GAIT:    cur.mode = MODE_SMOOTH_JOINT;
                            default:     cur.mode = MODE_SMOOTH_ABS;
                        endcase
                        if (have_prev) due_results.push_back(prev);
                        prev      = cur;
                        have_prev = 1'b1;
                    end
                end
            end
            for (int i = 0; i < JOINTS; i++) begin
                shadow_occ[i] = 1'b0;
                shadow_src[i] = SRC_UI;
                shadow_ang[i] = '0;
            end
            if (have_prev) begin
                prev.last = 1'b1;
                due_results.push_back(prev);
            end else begin
                due_results.push_back(status_result(1'b0, 1'b0, '0));
            end
        end
    endtask

    task automatic check_field(input string what, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, what, want, got);
            fail_count++;
        end
    endtask

    // monitor: input acceptance feeds the shadow, results are checked
    always @(posedge aclk) begin
        joint_req_t    q;
        joint_result_t want;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (due_results.size() == 0) begin
                    $display("%0t: unexpected result, actual tdata 0x%0h tuser %0b",
                             $time, m_tdata, m_tuser);
                    fail_count++;
                end else begin
                    want = due_results.pop_front();
                    check_field("cmd_valid", want.cmd_valid, m_tuser);
                    check_field("cmd_channel", want.chan, m_tdata[5:0]);
                    check_field("cmd_angle", want.ang, m_tdata[21:6]);
                    check_field("write_mode", want.mode, m_tdata[23:22]);
                    check_field("last", want.last, m_tlast);
                    check_field("accepted", want.acc, m_tdata[24]);
                    check_field("out_of_range", want.oor, m_tdata[25]);
                    check_field("pending_count", want.pend, m_tdata[32:26]);
                    check_field("padding", 0, m_tdata[39:33]);
                end
            end
            if (s_tvalid && s_tready) begin
                q.kind  = s_tuser;
                q.src   = s_tdata[1:0];
                q.chan  = s_tdata[9:2];
                q.ang   = s_tdata[25:10];
                q.estop = s_tdata[26];
                merge_item(q);
                reqs_taken++;
            end
        end
    end

    // driver: offers the next queued item once the current one is taken
    always @(negedge aclk) begin
        joint_req_t q;
        if (aresetn && reqs_taken == reqs_offered) begin
            if (req_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                q = req_q.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= q.kind;
                s_tdata  <= {5'b0, q.estop, q.ang, q.chan, q.src};
                reqs_offered++;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: random back-pressure plus one long hold-off
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (hold_arm && !hold_used) begin
            hold_used = 1'b1;
            hold_left = 300;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic push_submit(input logic [SRC_W-1:0] src, input logic [CHAN_W-1:0] chan,
                               input logic [ANGLE_W-1:0] ang, input logic estop);
        req_q.push_back(joint_req_t'{REQ_SUBMIT, src, chan, ang, estop});
    endtask

    task automatic push_flush(input logic estop);
        req_q.push_back(joint_req_t'{REQ_FLUSH, SRC_W'($urandom), CHAN_W'($urandom),
                                     ANGLE_W'($urandom), estop});
    endtask

    // mostly whole control ticks: a few submits then a flush, some noise
    task automatic push_random(input int unsigned count);
        int unsigned added;
        int unsigned subs;
        logic [CHAN_W-1:0] chan;
        added = 0;
        while (added < count) begin
            if ($urandom_range(9) == 0) begin
                req_q.push_back(joint_req_t'($urandom));
                added++;
            end else begin
                subs = $urandom_range(1, 8);
                for (int i = 0; i < subs; i++) begin
                    if ($urandom_range(99) < 85) chan = CHAN_W'($urandom_range(JOINTS - 1));
                    else chan = CHAN_W'($urandom_range(255, JOINTS));
                    push_submit(SRC_W'($urandom_range(3)), chan, ANGLE_W'($urandom),
                                1'($urandom_range(1)));
                end
                push_flush($urandom_range(99) < 15);
                added += subs + 1;
            end
        end
    endtask

    // wait until every item is taken and every result has come back
    task automatic drain();
        while (req_q.size() > 0 || reqs_taken != reqs_offered || due_results.size() > 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic set_gateway(input logic v);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        gateway_on = v;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // test sequence
    initial begin
        for (int i = 0; i < JOINTS; i++) begin
            shadow_occ[i] = 1'b0;
            shadow_src[i] = SRC_UI;
            shadow_ang[i] = '0;
        end
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // gateway detached: submits at field extremes, flushes keep the slots
        send_idle_pct = 23;
        recv_idle_pct = 78;
        set_gateway(1'b0);
        push_submit(SRC_UI, 8'd0, 16'h8000, 1'b0);
        push_submit(SRC_UNKNOWN, 8'd15, 16'h7fff, 1'b1);
        push_submit(SRC_BALANCE, 8'd16, 16'h0001, 1'b0);
        push_submit(SRC_GAIT, 8'd255, 16'hffff, 1'b1);
        push_flush(1'b1);
        push_flush(1'b0);
        drain();

        // gateway attached: priority merge, silent unknown slots, estop
        set_gateway(1'b1);
        push_submit(SRC_GAIT, 8'd3, 16'd100, 1'b0);
        push_submit(SRC_UI, 8'd3, 16'd200, 1'b0);
        push_submit(SRC_GAIT, 8'd3, 16'd300, 1'b0);
        push_submit(SRC_BALANCE, 8'd3, 16'hfffb, 1'b0);
        push_submit(SRC_UI, 8'd4, 16'd1, 1'b0);
        push_submit(SRC_GAIT, 8'd5, 16'hffff, 1'b0);
        push_submit(SRC_UNKNOWN, 8'd7, 16'd7, 1'b0);
        push_submit(SRC_BALANCE, 8'd15, 16'd15, 1'b0);
        push_flush(1'b0);
        push_flush(1'b0);
        push_submit(SRC_BALANCE, 8'd1, 16'd11, 1'b0);
        push_submit(SRC_UNKNOWN, 8'd1, 16'd12, 1'b0);
        push_flush(1'b0);
        push_submit(SRC_UI, 8'd2, 16'd22, 1'b0);
        push_flush(1'b1);
        push_flush(1'b0);
        drain();

        push_random(15);
        drain();

        // sender slow, receiver eager
        send_idle_pct = 78;
        recv_idle_pct = 23;
        set_gateway(1'b0);
        push_random(8);
        drain();
        set_gateway(1'b1);
        push_random(15);
        drain();

        // no idling; a full set of slots while the receiver holds off
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < JOINTS; i++)
            push_submit(SRC_W'($urandom_range(2)), CHAN_W'(i), ANGLE_W'($urandom),
                        1'($urandom_range(1)));
        push_flush(1'b0);
        push_random(10);
        hold_arm = 1'b1;
        drain();

        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/jcpm_pkg.sv
hdl/jcpm_ram.sv
hdl/joint_command_priority_merge.sv
sim/tb_joint_command_priority_merge.sv
